// File: rtl/fan_speed_p_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Fan speed controller assertion macros
// Shared property forms for the checks in the controller RTL; the user's
// module must provide clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_P_CONTROLLER_CORE_ASSERT_SVH
`define FAN_SPEED_P_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define FSPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fan speed controller check failed");

// Next-cycle implication, held off during reset.
`define FSPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fan speed controller check failed");

`endif

// File: rtl/fspc_pkg.sv
// ----------------------------------------------------------------------------
// Fan speed controller package
// Payload types, pipeline record and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package fspc_pkg;

  // Quotient bits produced by the speed divider; one per stage.
  localparam int unsigned DivSteps = 16;

  // Half a minute at 40 MHz: the dividend that turns a tach period into rpm.
  localparam logic [30:0] TicksHalfMin = 31'd1200000000;
  // Periods at or below this give more than 65535 rpm.
  localparam logic [31:0] SatPeriod    = 32'd18310;
  localparam logic [15:0] RpmMax       = 16'hFFFF;
  localparam logic [13:0] DisplayMax   = 14'd9999;

  localparam logic [9:0]  TargetNum    = 10'd586;
  // ceil(2^32 / 1000): exact floor division for products below 2^22.
  localparam logic [22:0] TargetRecip  = 23'd4294968;
  // ceil(2^16 / 24): target * 100 / 2400 == target / 24.
  localparam logic [11:0] DutyRecip    = 12'd2731;
  localparam logic [6:0]  DutyFull     = 7'd100;
  localparam logic [10:0] DutyScale    = 11'd1038;
  localparam logic [16:0] DriveDen     = 17'd100000;
  // ceil(2^40 / 3125): divide by 100000 as >> 5 then / 3125.
  localparam logic [28:0] DriveRecip   = 29'd351843721;

  // Decimal digit reciprocals.
  localparam logic [14:0] Recip1000    = 15'd16778;  // 2^24 scale
  localparam logic [9:0]  Recip100     = 10'd656;    // 2^16 scale
  localparam logic [6:0]  Recip10      = 7'd103;     // 2^10 scale

  typedef struct packed {
    logic [11:0] setpoint_sample;
    logic [31:0] tach_period;
  } in_item_t;

  typedef struct packed {
    logic [11:0] target_rpm;
    logic [15:0] measured_rpm;
    logic [15:0] pulse_width;
    logic [3:0]  digit_thousands;
    logic [3:0]  digit_hundreds;
    logic [3:0]  digit_tens;
  } out_item_t;

  // Record carried through the divider stages.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] divisor;
    logic [15:0] quot;
    logic        sat;
    logic [21:0] scaled_sp;
    logic [11:0] target;
    logic [6:0]  duty;
  } div_item_t;

endpackage

// File: rtl/fspc_div_step.sv
// ----------------------------------------------------------------------------
// Fan speed controller divider step
// One restoring-division step and its pipeline register.
// ----------------------------------------------------------------------------
module fspc_div_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  dvd_bit_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  fspc_pkg::div_item_t   data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output fspc_pkg::div_item_t   data_o
);
  import fspc_pkg::*;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;
  div_item_t   data_d;
  div_item_t   data_q;
  logic        valid_q;

  // Bring down the next dividend bit, subtract where the divisor fits.
  always_comb begin
    trial       = {data_i.rem, dvd_bit_i};
    diff        = trial - {1'b0, data_i.divisor};
    fits        = (trial >= {1'b0, data_i.divisor});
    data_d      = data_i;
    data_d.rem  = fits ? diff[31:0] : trial[31:0];
    data_d.quot = {data_i.quot[DivSteps-2:0], fits};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: rtl/fspc_drive.sv
// ----------------------------------------------------------------------------
// Fan speed controller drive stages
// Error term, clamped drive, PWM scaling and display digits in four stages.
// ----------------------------------------------------------------------------
module fspc_drive (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           pwm_load_i,
  input  logic [7:0]            p_gain_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  fspc_pkg::div_item_t   data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output fspc_pkg::out_item_t   data_o
);
  import fspc_pkg::*;

  typedef struct packed {
    logic [11:0]        target;
    logic [15:0]        rpm;
    logic signed [26:0] gprod;
    logic [16:0]        duty_sc;
    logic [13:0]        shown;
    logic [3:0]         th;
  } p1_t;

  typedef struct packed {
    logic [11:0] target;
    logic [15:0] rpm;
    logic [16:0] dclamp;
    logic [3:0]  th;
    logic [9:0]  r1;
    logic [3:0]  hu;
  } p2_t;

  typedef struct packed {
    logic [11:0] target;
    logic [15:0] rpm;
    logic [32:0] prod;
    logic [3:0]  th;
    logic [3:0]  hu;
    logic [3:0]  te;
  } p3_t;

  logic [3:0] valid_q;
  logic [3:0] rdy;
  p1_t        p1_d, p1_q;
  p2_t        p2_d, p2_q;
  p3_t        p3_d, p3_q;
  out_item_t  p4_d, p4_q;

  logic [15:0]        rpm;
  logic signed [17:0] err;
  logic [28:0]        th_prod;
  logic signed [26:0] drv;
  logic [13:0]        th_scaled;
  logic [13:0]        r1_full;
  logic [19:0]        hu_prod;
  logic [9:0]         hu_scaled;
  logic [6:0]         r2;
  logic [13:0]        te_prod;
  logic [56:0]        pw_prod;

  // Stage 1: measured speed, gain times error, base duty, thousands digit.
  always_comb begin
    rpm          = data_i.sat ? RpmMax : data_i.quot;
    err          = $signed({6'd0, data_i.target}) - $signed({2'd0, rpm});
    p1_d.target  = data_i.target;
    p1_d.rpm     = rpm;
    p1_d.gprod   = $signed({19'd0, p_gain_i}) * $signed({{9{err[17]}}, err});
    p1_d.duty_sc = {10'd0, data_i.duty} * {6'd0, DutyScale};
    p1_d.shown   = (rpm > {2'd0, DisplayMax}) ? DisplayMax : rpm[13:0];
    th_prod      = {15'd0, p1_d.shown} * {14'd0, Recip1000};
    p1_d.th      = th_prod[27:24];
  end

  // Stage 2: drive, clamped to 0..full scale, and hundreds digit.
  always_comb begin
    drv         = $signed({10'd0, p1_q.duty_sc}) - p1_q.gprod;
    p2_d.target = p1_q.target;
    p2_d.rpm    = p1_q.rpm;
    p2_d.th     = p1_q.th;
    if (drv[26] || (drv == '0)) begin
      p2_d.dclamp = '0;
    end else if (drv > $signed({10'd0, DriveDen})) begin
      p2_d.dclamp = DriveDen;
    end else begin
      p2_d.dclamp = drv[16:0];
    end
    th_scaled = {10'd0, p1_q.th} * 14'd1000;
    r1_full   = p1_q.shown - th_scaled;
    p2_d.r1   = r1_full[9:0];
    hu_prod   = {10'd0, p2_d.r1} * {10'd0, Recip100};
    p2_d.hu   = hu_prod[19:16];
  end

  // Stage 3: scale by PWM period, tens digit.
  always_comb begin
    p3_d.target = p2_q.target;
    p3_d.rpm    = p2_q.rpm;
    p3_d.th     = p2_q.th;
    p3_d.hu     = p2_q.hu;
    p3_d.prod   = {16'd0, p2_q.dclamp} * {17'd0, pwm_load_i};
    hu_scaled   = {6'd0, p2_q.hu} * 10'd100;
    r2          = p2_q.r1[6:0] - hu_scaled[6:0];
    te_prod     = {7'd0, r2} * {7'd0, Recip10};
    p3_d.te     = te_prod[13:10];
  end

  // Stage 4: divide by 100000 as a shift and reciprocal multiply.
  always_comb begin
    pw_prod              = {29'd0, p3_q.prod[32:5]} * {28'd0, DriveRecip};
    p4_d.target_rpm      = p3_q.target;
    p4_d.measured_rpm    = p3_q.rpm;
    p4_d.pulse_width     = pw_prod[55:40];
    p4_d.digit_thousands = p3_q.th;
    p4_d.digit_hundreds  = p3_q.hu;
    p4_d.digit_tens      = p3_q.te;
  end

  // Each stage loads when empty or when its successor takes its transfer.
  assign rdy[3]  = !valid_q[3] || ready_i;
  assign rdy[2]  = !valid_q[2] || rdy[3];
  assign rdy[1]  = !valid_q[1] || rdy[2];
  assign rdy[0]  = !valid_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = valid_q[3];
  assign data_o  = p4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= valid_i;
      if (rdy[1]) valid_q[1] <= valid_q[0];
      if (rdy[2]) valid_q[2] <= valid_q[1];
      if (rdy[3]) valid_q[3] <= valid_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i)    p1_q <= p1_d;
    if (rdy[1] && valid_q[0]) p2_q <= p2_d;
    if (rdy[2] && valid_q[1]) p3_q <= p3_d;
    if (rdy[3] && valid_q[2]) p4_q <= p4_d;
  end

endmodule

// File: rtl/fan_speed_p_controller_core.sv
// ----------------------------------------------------------------------------
// Proportional fan speed controller core
// Turns a set-point sample and a tachometer period into a PWM compare value,
// the target and measured speeds, and three display digits.
// ----------------------------------------------------------------------------
// Pipelined at one transfer per clock unless the output stalls: an accepted
// item passes through 16 divider stages, then 4 drive stages, 20 registers in
// all with the last as the output register, and a new item may be accepted
// every cycle while no stall holds off the input. The
// depth is set by the speed divider,
// which retires one quotient bit per stage with a 33-bit compare and subtract.
// Every stage holds its own valid bit and loads when empty or when its
// successor moves on, so a stall at the output fills bubbles first and only
// then holds off the input. pwm_load and p_gain sit on the APB port (byte
// addresses 0 and 4, paddr[2] selects) and must be written only with the
// pipeline empty.
`include "fan_speed_p_controller_core_assert.svh"

module fan_speed_p_controller_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fspc_pkg::in_item_t   in_data_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fspc_pkg::out_item_t  out_data_o,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import fspc_pkg::*;

  typedef enum logic {
    RegPwmLoad = 1'b0,
    RegPGain   = 1'b1
  } reg_idx_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] pwm_load_q;
  logic [7:0]  p_gain_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  // Low address bits are ignored: every write lands on one of the two registers.
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_load_q <= 16'd780;
      p_gain_q   <= 8'd40;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegPwmLoad: pwm_load_q <= pwdata[15:0];
        RegPGain:   p_gain_q   <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegPwmLoad: prdata = {16'd0, pwm_load_q};
      RegPGain:   prdata = {24'd0, p_gain_q};
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Entry: seed the divider. 1.2e9 / period fits 16 bits once period > 18310,
  // so the partial remainder starts as the dividend's upper 15 bits and the
  // lower 16 bits come down one per stage. Shorter periods (and zero) saturate.
  // --------------------------------------------------------------------------
  div_item_t front;

  always_comb begin
    front           = '0;
    front.rem       = 32'(TicksHalfMin >> DivSteps);
    front.divisor   = in_data_i.tach_period;
    front.sat       = (in_data_i.tach_period <= SatPeriod);
    front.scaled_sp = {10'd0, in_data_i.setpoint_sample} * {12'd0, TargetNum};
  end

  // --------------------------------------------------------------------------
  // Divider chain. The target path rides along: target rpm is formed between
  // the first two stages and the base duty between the second and third.
  // --------------------------------------------------------------------------
  div_item_t            st_in  [DivSteps];
  div_item_t            st_out [DivSteps];
  logic [DivSteps-1:0]  st_in_valid;
  logic [DivSteps-1:0]  st_in_ready;
  logic [DivSteps-1:0]  st_out_valid;
  logic [DivSteps-1:0]  st_out_ready;
  logic [44:0]          tgt_prod;
  logic [23:0]          duty_prod;
  logic                 drv_ready;

  // floor(sample * 586 / 1000) by reciprocal multiply.
  assign tgt_prod  = {23'd0, st_out[0].scaled_sp} * {22'd0, TargetRecip};
  // floor(target / 24) by reciprocal multiply.
  assign duty_prod = {12'd0, st_out[1].target} * {12'd0, DutyRecip};

  assign in_ready_o = st_in_ready[0];

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    if (i == 0) begin : g_first
      assign st_in[i]       = front;
      assign st_in_valid[i] = in_valid_i;
    end else if (i == 1) begin : g_target
      always_comb begin
        st_in[i]        = st_out[i-1];
        st_in[i].target = tgt_prod[43:32];
      end
      assign st_in_valid[i] = st_out_valid[i-1];
    end else if (i == 2) begin : g_duty
      always_comb begin
        st_in[i]      = st_out[i-1];
        st_in[i].duty = DutyFull - duty_prod[22:16];
      end
      assign st_in_valid[i] = st_out_valid[i-1];
    end else begin : g_pass
      assign st_in[i]       = st_out[i-1];
      assign st_in_valid[i] = st_out_valid[i-1];
    end

    if (i < DivSteps - 1) begin : g_link
      assign st_out_ready[i] = st_in_ready[i+1];
    end else begin : g_last
      assign st_out_ready[i] = drv_ready;
    end

    fspc_div_step u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .dvd_bit_i (TicksHalfMin[DivSteps-1-i]),
      .valid_i   (st_in_valid[i]),
      .ready_o   (st_in_ready[i]),
      .data_i    (st_in[i]),
      .valid_o   (st_out_valid[i]),
      .ready_i   (st_out_ready[i]),
      .data_o    (st_out[i])
    );
  end

  // --------------------------------------------------------------------------
  // Drive, clamp, PWM scaling and display digits; last stage is the output
  // register.
  // --------------------------------------------------------------------------
  fspc_drive u_drive (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pwm_load_i (pwm_load_q),
    .p_gain_i   (p_gain_q),
    .valid_i    (st_out_valid[DivSteps-1]),
    .ready_o    (drv_ready),
    .data_i     (st_out[DivSteps-1]),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (out_data_o)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // A transfer in must show up in the first divider stage.
  `FSPC_ASSERT_NEXT(a_entry_loads, in_valid_i && in_ready_o, st_out_valid[0])
  // Pulse width never exceeds the PWM period.
  `FSPC_ASSERT_NOW(a_pw_in_load, out_valid_o, out_data_o.pulse_width <= pwm_load_q)
  // Target speed stays within the knob's range.
  `FSPC_ASSERT_NOW(a_target_range, out_valid_o, out_data_o.target_rpm <= 12'd2399)
  // Below 1000 rpm the thousands digit is blank.
  `FSPC_ASSERT_NOW(a_slow_digit, out_valid_o && (out_data_o.measured_rpm < 16'd1000), out_data_o.digit_thousands == 4'd0)

endmodule
